[rtl/core/sgce_pkg.sv]
`default_nettype none
package sgce_pkg;

  localparam int LEN_BITS     = 20;
  localparam int COST_BITS    = 32;
  localparam int DEF_SCOPES   = 4;
  localparam int DEF_ENTRIES  = 256;
  // squared-distance width and interpolation dividend width
  localparam int DIST_BITS    = 2 * LEN_BITS + 1;
  localparam int PROD_BITS    = 2 * COST_BITS + DIST_BITS;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_SCOPE    = 2'd1,
    OP_ENTRY    = 2'd2,
    OP_ESTIMATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NO_SCOPE  = 3'd2,
    ST_MISSING   = 3'd3,
    ST_FULL      = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  localparam logic [1:0] MODE_FLOOR = 2'd1;
  localparam logic [1:0] MODE_MEAN  = 2'd2;

  typedef enum logic [1:0] {
    DIV_P,
    DIV_I,
    DIV_X
  } div_sel_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_FLOOR,
    VAL_CEIL,
    VAL_MEAN
  } val_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ENT_LK,
    S_SCAN,
    S_DIV_P,
    S_DIV_I,
    S_LK_GO,
    S_LOOK,
    S_MEAN0,
    S_MEAN1,
    S_XMUL,
    S_DIV_X,
    S_SQRT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [LEN_BITS-1:0] prefix_len;
    logic [LEN_BITS-1:0] input_len;
    logic [LEN_BITS-1:0] pfx_stride;
    logic [LEN_BITS-1:0] inl_stride;
    logic [1:0]          mode;
    logic [COST_BITS-1:0] cost;
  } in_t;

  typedef struct packed {
    logic [COST_BITS-1:0] estimate_value;
    logic [2:0]           status;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     scope_wr;
    logic     ent_wr;
    logic     scan_next;
    logic     lk_start;
    logic     lk_grid;
    logic     div_start;
    div_sel_t div_sel;
    logic     mean_a;
    logic     mean_b;
    logic     xmul_start;
    logic     sqrt_start;
    logic     emit;
    status_t  status;
    val_sel_t val_sel;
  } cmd_t;

  typedef struct packed {
    op_t        op;
    logic       scope_full;
    logic       scope_none;
    logic       out_range;
    logic       scope_hit;
    logic       scan_last;
    logic       ent_full;
    logic       lk_done;
    logic       lk_fa;
    logic       lk_fb;
    logic       div_done;
    logic       on_grid;
    logic [1:0] mode;
    logic       xmul_done;
    logic       sqrt_done;
  } sts_t;

endpackage
`default_nettype wire

[rtl/core/sgce_ctrl.sv]
`default_nettype none
module sgce_ctrl
  import sgce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.status  = ST_OK;
    cmd.val_sel = VAL_ZERO;
    cmd.div_sel = DIV_P;
    busy        = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_SCOPE: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
            if (sts.scope_full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.scope_wr = 1'b1;
            end
          end
          OP_ENTRY: begin
            if (sts.ent_full) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_FULL;
              state_nxt  = S_IDLE;
            end else begin
              cmd.lk_start = 1'b1;
              state_nxt    = S_ENT_LK;
            end
          end
          default: begin
            if (sts.scope_none) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_NO_SCOPE;
              state_nxt  = S_IDLE;
            end else if (sts.out_range) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_RANGE;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_ENT_LK: begin
        if (sts.lk_done) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
          if (sts.lk_fa) begin
            cmd.status = ST_DUPLICATE;
          end else begin
            cmd.ent_wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (sts.scope_hit) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_P;
          state_nxt     = S_DIV_P;
        end else if (sts.scan_last) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_NO_SCOPE;
          state_nxt  = S_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DIV_P: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_I;
          state_nxt     = S_DIV_I;
        end
      end
      S_DIV_I: begin
        if (sts.div_done) begin
          state_nxt = S_LK_GO;
        end
      end
      S_LK_GO: begin
        cmd.lk_start = 1'b1;
        cmd.lk_grid  = 1'b1;
        state_nxt    = S_LOOK;
      end
      S_LOOK: begin
        if (sts.lk_done) begin
          if (!(sts.lk_fa && sts.lk_fb)) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_MISSING;
            state_nxt  = S_IDLE;
          end else if (sts.on_grid || sts.mode == MODE_FLOOR) begin
            cmd.emit    = 1'b1;
            cmd.val_sel = VAL_FLOOR;
            state_nxt   = S_IDLE;
          end else if (sts.mode == MODE_MEAN) begin
            state_nxt = S_MEAN0;
          end else begin
            cmd.emit    = 1'b1;
            cmd.val_sel = VAL_CEIL;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_MEAN0: begin
        cmd.mean_a = 1'b1;
        state_nxt  = S_MEAN1;
      end
      S_MEAN1: begin
        cmd.mean_b = 1'b1;
        state_nxt  = S_XMUL;
      end
      S_XMUL: begin
        if (sts.xmul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_X;
          state_nxt     = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.emit    = 1'b1;
          cmd.val_sel = VAL_MEAN;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // the multiply step is started by the cycle that loads its operands
    if (state_r == S_MEAN1) begin
      cmd.xmul_start = 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/sgce_dp.sv]
`default_nettype none
module sgce_dp
  import sgce_pkg::*;
#(
  parameter int MAX_SCOPES  = DEF_SCOPES,
  parameter int MAX_ENTRIES = DEF_ENTRIES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int SCW = $clog2(MAX_SCOPES + 1);
  localparam int SIW = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int KW  = 2 * LEN_BITS;
  localparam int DCW = $clog2(PROD_BITS + 1);
  localparam int MCW = $clog2(DIST_BITS + 1);
  localparam int RCW = $clog2(COST_BITS + 1);
  localparam int LB  = LEN_BITS;
  localparam int CB  = COST_BITS;

  in_t item_r;

  // scope store
  logic [LB-1:0] bnd_p_r  [MAX_SCOPES];
  logic [LB-1:0] bnd_i_r  [MAX_SCOPES];
  logic [LB-1:0] stp_p_r  [MAX_SCOPES];
  logic [LB-1:0] stp_i_r  [MAX_SCOPES];
  logic [1:0]    smode_r  [MAX_SCOPES];
  logic [SCW-1:0] scope_cnt_r;
  logic [SCW-1:0] scan_idx_r;
  logic [LB-1:0] last_bp_r, last_bi_r;
  logic [LB-1:0] sel_ps_r, sel_is_r;
  logic [1:0]    sel_mode_r;

  // entry store
  logic [KW-1:0] ekey_mem [MAX_ENTRIES];
  logic [CB-1:0] ecost_mem [MAX_ENTRIES];
  logic [CW-1:0] ent_cnt_r;
  logic [KW-1:0] rd_key_r;
  logic [CB-1:0] rd_cost_r;

  // lookup
  logic [KW-1:0] ka_r, kb_r;
  logic          b_never_r;
  logic [CW-1:0] addr_r;
  logic          rvld_r, lbusy_r, ldone_r, fa_r, fb_r;
  logic [CB-1:0] va_r, vb_r;

  // divider
  logic [PROD_BITS-1:0] dq_r;
  logic [DIST_BITS-1:0] drem_r, dvs_r;
  logic [DCW-1:0]       dcnt_r;
  logic                 dbusy_r, ddone_r;
  div_sel_t             dsel_r;
  logic [DIST_BITS:0]   dshift;
  logic [LB-1:0]        rp_r, ri_r;

  // interpolation
  logic [CB-1:0]        diff_r;
  logic                 up_r;
  logic [2*LB-1:0]      dp2_r, di2_r, cp2_r, ci2_r;
  logic [2*CB-1:0]      dsq_r;
  logic [DIST_BITS-1:0] d1_r, d2_r;
  logic [PROD_BITS-1:0] x_r;
  logic [MCW-1:0]       mcnt_r;
  logic                 mbusy_r, mdone_r;
  logic [2*CB-1:0]      sq_in_r;
  logic [CB-1:0]        root_r;
  logic [CB+1:0]        srem_r;
  logic [RCW-1:0]       scnt_r;
  logic                 sbusy_r, sdone_r;
  logic [CB+3:0]        s_rem2, s_trial;

  // grid points
  logic [LB-1:0] pf, inf;
  logic [LB:0]   pc, ic;
  logic          on_grid;
  logic [CB-1:0] sel_val;

  assign pf      = item_r.prefix_len - rp_r;
  assign inf     = item_r.input_len - ri_r;
  assign pc      = (rp_r == '0) ? {1'b0, item_r.prefix_len} : {1'b0, pf} + {1'b0, sel_ps_r};
  assign ic      = (ri_r == '0) ? {1'b0, item_r.input_len} : {1'b0, inf} + {1'b0, sel_is_r};
  assign on_grid = (rp_r == '0) && (ri_r == '0);

  assign dshift  = {drem_r, dq_r[PROD_BITS-1]};
  assign s_rem2  = {srem_r, sq_in_r[2*CB-1 -: 2]};
  assign s_trial = {2'b00, root_r, 2'b01};

  always_comb begin
    sts            = '0;
    sts.op         = op_t'(item_r.op);
    sts.scope_full = (scope_cnt_r == SCW'(MAX_SCOPES));
    sts.scope_none = (scope_cnt_r == '0);
    sts.out_range  = (item_r.input_len == '0) || (item_r.prefix_len > last_bp_r) ||
                     (item_r.input_len > last_bi_r);
    sts.scope_hit  = (bnd_p_r[scan_idx_r[SIW-1:0]] >= item_r.prefix_len) &&
                     (bnd_i_r[scan_idx_r[SIW-1:0]] >= item_r.input_len);
    sts.scan_last  = (scan_idx_r == scope_cnt_r - SCW'(1));
    sts.ent_full   = (ent_cnt_r == CW'(MAX_ENTRIES));
    sts.lk_done    = ldone_r;
    sts.lk_fa      = fa_r;
    sts.lk_fb      = fb_r;
    sts.div_done   = ddone_r;
    sts.on_grid    = on_grid;
    sts.mode       = sel_mode_r;
    sts.xmul_done  = mdone_r;
    sts.sqrt_done  = sdone_r;
  end

  always_comb begin
    case (cmd.val_sel)
      VAL_FLOOR: sel_val = va_r;
      VAL_CEIL:  sel_val = vb_r;
      VAL_MEAN:  sel_val = up_r ? va_r + root_r : va_r - root_r;
      default:   sel_val = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scope_cnt_r <= '0;
      ent_cnt_r   <= '0;
      scan_idx_r  <= '0;
      out_valid   <= 1'b0;
      lbusy_r     <= 1'b0;
      ldone_r     <= 1'b0;
      rvld_r      <= 1'b0;
      dbusy_r     <= 1'b0;
      ddone_r     <= 1'b0;
      mbusy_r     <= 1'b0;
      mdone_r     <= 1'b0;
      sbusy_r     <= 1'b0;
      sdone_r     <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      ldone_r   <= 1'b0;
      ddone_r   <= 1'b0;
      mdone_r   <= 1'b0;
      sdone_r   <= 1'b0;
      if (cmd.clear) begin
        scope_cnt_r <= '0;
        ent_cnt_r   <= '0;
      end
      if (cmd.scope_wr) begin
        scope_cnt_r <= scope_cnt_r + SCW'(1);
      end
      if (cmd.ent_wr) begin
        ent_cnt_r <= ent_cnt_r + CW'(1);
      end
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_next) begin
        scan_idx_r <= scan_idx_r + SCW'(1);
      end
      // lookup sweep
      if (cmd.lk_start) begin
        lbusy_r <= 1'b1;
        rvld_r  <= 1'b0;
      end else if (lbusy_r) begin
        rvld_r <= (addr_r != ent_cnt_r);
        if (addr_r == ent_cnt_r && !rvld_r) begin
          lbusy_r <= 1'b0;
          ldone_r <= 1'b1;
        end
      end
      // divider
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r == DCW'(1)) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end
      // multiplier
      if (cmd.xmul_start) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && mcnt_r == MCW'(1)) begin
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end
      // square root
      if (cmd.sqrt_start) begin
        sbusy_r <= 1'b1;
      end else if (sbusy_r && scnt_r == RCW'(1)) begin
        sbusy_r <= 1'b0;
        sdone_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.emit) begin
      out_data.estimate_value <= (cmd.status == ST_OK) ? sel_val : '0;
      out_data.status         <= cmd.status;
    end
    if (cmd.scope_wr) begin
      bnd_p_r[scope_cnt_r[SIW-1:0]] <= item_r.prefix_len;
      bnd_i_r[scope_cnt_r[SIW-1:0]] <= item_r.input_len;
      stp_p_r[scope_cnt_r[SIW-1:0]] <= (item_r.pfx_stride == '0) ? LB'(1) : item_r.pfx_stride;
      stp_i_r[scope_cnt_r[SIW-1:0]] <= (item_r.inl_stride == '0) ? LB'(1) : item_r.inl_stride;
      smode_r[scope_cnt_r[SIW-1:0]] <= item_r.mode;
      last_bp_r <= item_r.prefix_len;
      last_bi_r <= item_r.input_len;
    end

    // lookup: key (0,0) is always present with cost zero
    if (cmd.lk_start) begin
      addr_r <= '0;
      va_r   <= '0;
      vb_r   <= '0;
      if (cmd.lk_grid && !on_grid) begin
        ka_r      <= {pf, inf};
        kb_r      <= {pc[LB-1:0], ic[LB-1:0]};
        b_never_r <= pc[LB] | ic[LB];
        fa_r      <= (pf == '0) && (inf == '0);
        fb_r      <= (pc == '0) && (ic == '0);
      end else begin
        ka_r      <= {item_r.prefix_len, item_r.input_len};
        kb_r      <= {item_r.prefix_len, item_r.input_len};
        b_never_r <= 1'b0;
        fa_r      <= (item_r.prefix_len == '0) && (item_r.input_len == '0);
        fb_r      <= (item_r.prefix_len == '0) && (item_r.input_len == '0);
      end
    end else if (lbusy_r) begin
      if (addr_r != ent_cnt_r) begin
        addr_r <= addr_r + CW'(1);
      end
      if (rvld_r && rd_key_r == ka_r) begin
        fa_r <= 1'b1;
        va_r <= rd_cost_r;
      end
      if (rvld_r && rd_key_r == kb_r && !b_never_r) begin
        fb_r <= 1'b1;
        vb_r <= rd_cost_r;
      end
    end

    // restoring divider, one quotient bit per cycle
    if (cmd.div_start) begin
      drem_r <= '0;
      dsel_r <= cmd.div_sel;
      case (cmd.div_sel)
        DIV_P: begin
          dq_r       <= {item_r.prefix_len, {(PROD_BITS-LB){1'b0}}};
          dvs_r      <= DIST_BITS'(stp_p_r[scan_idx_r[SIW-1:0]]);
          dcnt_r     <= DCW'(LB);
          sel_ps_r   <= stp_p_r[scan_idx_r[SIW-1:0]];
          sel_is_r   <= stp_i_r[scan_idx_r[SIW-1:0]];
          sel_mode_r <= smode_r[scan_idx_r[SIW-1:0]];
        end
        DIV_I: begin
          dq_r   <= {item_r.input_len, {(PROD_BITS-LB){1'b0}}};
          dvs_r  <= DIST_BITS'(sel_is_r);
          dcnt_r <= DCW'(LB);
        end
        default: begin
          dq_r   <= x_r;
          dvs_r  <= d2_r;
          dcnt_r <= DCW'(PROD_BITS);
        end
      endcase
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r - DCW'(1);
      if (dshift >= {1'b0, dvs_r}) begin
        drem_r <= DIST_BITS'(dshift - {1'b0, dvs_r});
        dq_r   <= {dq_r[PROD_BITS-2:0], 1'b1};
      end else begin
        drem_r <= dshift[DIST_BITS-1:0];
        dq_r   <= {dq_r[PROD_BITS-2:0], 1'b0};
      end
    end
    if (ddone_r && dsel_r == DIV_P) begin
      rp_r <= drem_r[LB-1:0];
    end
    if (ddone_r && dsel_r == DIV_I) begin
      ri_r <= drem_r[LB-1:0];
    end

    // interpolation operands
    if (cmd.mean_a) begin
      up_r   <= (vb_r >= va_r);
      diff_r <= (vb_r >= va_r) ? vb_r - va_r : va_r - vb_r;
      dp2_r  <= (2*LB)'(rp_r) * (2*LB)'(rp_r);
      di2_r  <= (2*LB)'(ri_r) * (2*LB)'(ri_r);
      cp2_r  <= (rp_r == '0) ? '0 : (2*LB)'(sel_ps_r) * (2*LB)'(sel_ps_r);
      ci2_r  <= (ri_r == '0) ? '0 : (2*LB)'(sel_is_r) * (2*LB)'(sel_is_r);
    end
    if (cmd.mean_b) begin
      dsq_r <= (2*CB)'(diff_r) * (2*CB)'(diff_r);
      d1_r  <= {1'b0, dp2_r} + {1'b0, di2_r};
      d2_r  <= {1'b0, cp2_r} + {1'b0, ci2_r};
    end

    // shift-add multiply of the squared difference by d1, msb first
    if (cmd.xmul_start) begin
      x_r    <= '0;
      mcnt_r <= MCW'(DIST_BITS);
    end else if (mbusy_r) begin
      mcnt_r <= mcnt_r - MCW'(1);
      d1_r   <= {d1_r[DIST_BITS-2:0], 1'b0};
      x_r    <= {x_r[PROD_BITS-2:0], 1'b0} +
                (d1_r[DIST_BITS-1] ? PROD_BITS'(dsq_r) : '0);
    end

    // digit-by-digit square root, two radicand bits per cycle
    if (cmd.sqrt_start) begin
      sq_in_r <= dq_r[2*CB-1:0];
      root_r  <= '0;
      srem_r  <= '0;
      scnt_r  <= RCW'(CB);
    end else if (sbusy_r) begin
      scnt_r  <= scnt_r - RCW'(1);
      sq_in_r <= {sq_in_r[2*CB-3:0], 2'b00};
      if (s_rem2 >= s_trial) begin
        srem_r <= (CB+2)'(s_rem2 - s_trial);
        root_r <= {root_r[CB-2:0], 1'b1};
      end else begin
        srem_r <= s_rem2[CB+1:0];
        root_r <= {root_r[CB-2:0], 1'b0};
      end
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ent_wr) begin
      ekey_mem[ent_cnt_r[AW-1:0]]  <= {item_r.prefix_len, item_r.input_len};
      ecost_mem[ent_cnt_r[AW-1:0]] <= item_r.cost;
    end
    rd_key_r  <= ekey_mem[addr_r[AW-1:0]];
    rd_cost_r <= ecost_mem[addr_r[AW-1:0]];
  end

endmodule
`default_nettype wire

[rtl/core/scoped_grid_cost_estimator.sv]
// Channel   Ports                         Transfer
// input     start, busy, in_data          start high while busy low
// result    out_valid, out_data           out_valid high for one cycle
//
// Every item yields one result. Clear and scope append go straight to the
// strobe. Entry append sweeps the entry memory (one read per cycle) before
// its strobe. Estimate scans the scopes, runs two divides and sweeps the
// entry memory, and mean mode adds a multiply, a divide and a square root;
// the divider is bit-serial.
// Reset clears the counts and flags, not the stores, which need no clearing.
// The receiver cannot stall: busy drops as the result strobe goes out.
`default_nettype none
module scoped_grid_cost_estimator
  import sgce_pkg::*;
#(
  parameter int MAX_SCOPES  = DEF_SCOPES,
  parameter int MAX_ENTRIES = DEF_ENTRIES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  sgce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sgce_dp #(
    .MAX_SCOPES  (MAX_SCOPES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[sim/scoped_grid_cost_estimator_tb.sv]
`default_nettype none
module scoped_grid_cost_estimator_tb
  import sgce_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSCOPE = DEF_SCOPES;
  localparam int NENTRY = DEF_ENTRIES;
  localparam int IN_W   = $bits(in_t);
  localparam logic [LEN_BITS-1:0] LMAX = '1;

  class cost_scoreboard;
    logic [LEN_BITS-1:0]  bnd_p[NSCOPE], bnd_i[NSCOPE], stp_p[NSCOPE], stp_i[NSCOPE];
    logic [1:0]           smode[NSCOPE];
    int                   nscope;
    logic [LEN_BITS-1:0]  key_p[NENTRY], key_i[NENTRY];
    logic [COST_BITS-1:0] ecost[NENTRY];
    int                   nentry;
    out_t                 pending[$];
    int                   errors;

    function new();
      nscope = 0;
      nentry = 0;
      errors = 0;
    endfunction

    function bit lookup(longint p, longint i, output logic [COST_BITS-1:0] v);
      v = '0;
      if (p > LMAX || i > LMAX) return 0;
      if (p == 0 && i == 0) return 1;
      for (int k = 0; k < nentry; k++)
        if (key_p[k] == p && key_i[k] == i) begin
          v = ecost[k];
          return 1;
        end
      return 0;
    endfunction

    // largest m with m*m*d2 <= diff*diff*d1
    function logic [COST_BITS-1:0] blend(logic [COST_BITS-1:0] f, logic [COST_BITS-1:0] c,
                                         longint d1, longint d2);
      logic [127:0] diff, rhs, cand, lhs;
      logic [COST_BITS-1:0] m;
      diff = (c >= f) ? c - f : f - c;
      rhs = diff * diff * d1;
      m = '0;
      for (int b = COST_BITS - 1; b >= 0; b--) begin
        cand = m | (32'd1 << b);
        lhs = cand * cand * d2;
        if (lhs <= rhs) m = cand[COST_BITS-1:0];
      end
      return (c >= f) ? f + m : f - m;
    endfunction

    function status_t estimate(longint p, longint i, output logic [COST_BITS-1:0] v);
      int s;
      longint ps, is, pf, xf, pc, xc;
      logic [COST_BITS-1:0] fv, cv;
      v = '0;
      if (nscope == 0) return ST_NO_SCOPE;
      if (i == 0 || p > bnd_p[nscope-1] || i > bnd_i[nscope-1]) return ST_RANGE;
      for (s = 0; s < nscope; s++)
        if (bnd_p[s] >= p && bnd_i[s] >= i) break;
      if (s >= nscope) return ST_NO_SCOPE;
      ps = stp_p[s];
      is = stp_i[s];
      if (p % ps == 0 && i % is == 0) return lookup(p, i, v) ? ST_OK : ST_MISSING;
      pf = p / ps * ps;
      xf = i / is * is;
      pc = (p == 0) ? 0 : ((p - 1) / ps + 1) * ps;
      xc = (i == 0) ? 0 : ((i - 1) / is + 1) * is;
      if (!lookup(pf, xf, fv) || !lookup(pc, xc, cv)) return ST_MISSING;
      if (smode[s] == MODE_FLOOR) v = fv;
      else if (smode[s] == MODE_MEAN)
        v = blend(fv, cv, (p - pf) * (p - pf) + (i - xf) * (i - xf),
                  (pc - pf) * (pc - pf) + (xc - xf) * (xc - xf));
      else v = cv;
      return ST_OK;
    endfunction

    function void note(in_t it);
      out_t r;
      logic [COST_BITS-1:0] v;
      r = '0;
      r.status = ST_OK;
      case (it.op)
        OP_CLEAR: begin
          nscope = 0;
          nentry = 0;
        end
        OP_SCOPE: begin
          if (nscope >= NSCOPE) r.status = ST_FULL;
          else begin
            bnd_p[nscope] = it.prefix_len;
            bnd_i[nscope] = it.input_len;
            stp_p[nscope] = (it.pfx_stride == '0) ? LEN_BITS'(1) : it.pfx_stride;
            stp_i[nscope] = (it.inl_stride == '0) ? LEN_BITS'(1) : it.inl_stride;
            smode[nscope] = it.mode;
            nscope++;
          end
        end
        OP_ENTRY: begin
          if (nentry >= NENTRY) r.status = ST_FULL;
          else if (lookup(it.prefix_len, it.input_len, v)) r.status = ST_DUPLICATE;
          else begin
            key_p[nentry] = it.prefix_len;
            key_i[nentry] = it.input_len;
            ecost[nentry] = it.cost;
            nentry++;
          end
        end
        default: begin
          r.status = estimate(it.prefix_len, it.input_len, v);
          if (r.status == ST_OK) r.estimate_value = v;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time,
                 got.estimate_value, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.estimate_value !== want.estimate_value) begin
        $display("%0t: value expected %0d actual %0d", $time,
                 want.estimate_value, got.estimate_value);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid;
  in_t  in_data;
  out_t out_data;
  cost_scoreboard sb = new();
  int idle_pct = 0;

  scoped_grid_cost_estimator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_data);
  end

  function automatic in_t mk(op_t op, int p, int i);
    in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom});
    it.op = op;
    it.prefix_len = LEN_BITS'(p);
    it.input_len = LEN_BITS'(i);
    return it;
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send(input in_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(it);
    @(negedge clk);
  endtask

  task automatic add_scope(int bp, int bi, int sp, int si, int md);
    in_t it;
    it = mk(OP_SCOPE, bp, bi);
    it.pfx_stride = LEN_BITS'(sp);
    it.inl_stride = LEN_BITS'(si);
    it.mode = 2'(md);
    send(it);
  endtask

  task automatic add_entry(int p, int i, logic [COST_BITS-1:0] c);
    in_t it;
    it = mk(OP_ENTRY, p, i);
    it.cost = c;
    send(it);
  endtask

  task automatic query(int p, int i);
    send(mk(OP_ESTIMATE, p, i));
  endtask

  // clear, build scopes and grid entries, then query around them
  task automatic run_episode(ref int sent);
    int ns, bp, bi, sp, si, added, nq;
    int lp[NSCOPE], li[NSCOPE], tp[NSCOPE], ti[NSCOPE];
    send(mk(OP_CLEAR, 0, 0));
    ns = $urandom_range(1, NSCOPE);
    bp = 0;
    bi = 0;
    for (int s = 0; s < ns; s++) begin
      sp = $urandom_range(1, 6);
      si = $urandom_range(1, 6);
      bp += sp * $urandom_range(1, 3);
      bi += si * $urandom_range(1, 3);
      lp[s] = bp; li[s] = bi; tp[s] = sp; ti[s] = si;
      add_scope(bp, bi, sp, si, $urandom_range(0, 3));
    end
    sent += ns + 1;
    added = 0;
    for (int s = 0; s < ns; s++)
      for (int p = 0; p <= lp[s] + tp[s]; p += tp[s])
        for (int i = 0; i <= li[s] + ti[s]; i += ti[s])
          if (added < 60 && $urandom_range(99) < 80) begin
            add_entry(p, i, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1000));
            added++;
          end
    sent += added;
    nq = $urandom_range(8, 20);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(99) < 8) send(mk(op_t'($urandom_range(3)), $urandom, $urandom));
      else query($urandom_range(0, bp + 2), $urandom_range(0, bi + 2));
    end
    sent += nq;
  endtask

  initial begin
    int sent, wait_cyc;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    query(3, 3);
    send(mk(OP_CLEAR, LMAX, LMAX));
    add_scope(LMAX, LMAX, 0, 0, 3);
    add_entry(0, 0, 5);
    add_entry(5, 7, 32'hFFFF_FFFF);
    add_entry(5, 7, 1);
    query(5, 7);
    query(5, 0);
    query(LMAX, LMAX);
    send(mk(OP_CLEAR, 0, 0));
    add_scope(10, 10, 4, 4, 0);
    add_scope(20, 20, 4, 4, MODE_FLOOR);
    add_scope(30, 30, 4, 4, MODE_MEAN);
    add_scope(LMAX, LMAX, 600000, 600000, 3);
    add_scope(40, 40, 1, 1, 0);
    add_entry(4, 4, 100);
    add_entry(8, 8, 20);
    add_entry(12, 12, 7);
    add_entry(16, 16, 9);
    add_entry(20, 20, 5);
    add_entry(24, 24, 1000);
    add_entry(28, 28, 32'hFFFF_FFFF);
    add_entry(32, 32, 0);
    add_entry(600000, 600000, 55);
    query(2, 2);
    query(5, 5);
    query(13, 13);
    query(22, 23);
    query(29, 29);
    query(300000, 300000);
    query(700000, 700000);
    query(LMAX, 1);

    // fill the entry table; full takes precedence over duplicate
    send(mk(OP_CLEAR, 0, 0));
    for (int k = 0; k < NENTRY; k++) add_entry(k + 1, k, $urandom);
    add_entry(LMAX, LMAX, 1);
    add_entry(1, 0, 1);
    query(NENTRY, NENTRY - 1);

    sent = 0;
    while (sent < 300) begin
      case (sent * 4 / 300)
        0: idle_pct = 0;
        1: idle_pct = 57;
        2: idle_pct = 37;
        default: idle_pct = 0;
      endcase
      run_episode(sent);
    end
    start <= 1'b0;

    wait_cyc = 0;
    while (sb.pending.size() != 0 && wait_cyc < 5000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
